### rtl/core/rtc3w_pkg.sv
// ----------------------------------------------------------------------------
// rtc3w_pkg
// Types, codes and constants shared by the three-wire RTC serial master.
// ----------------------------------------------------------------------------
package rtc3w_pkg;

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_END   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_START_HOLD = 2'd0,
		CFG_HALF_BIT   = 2'd1
	} cfg_idx_t;

	// What the item in the working stage turns into
	typedef enum logic [2:0] {
		KIND_BEGIN,
		KIND_WRITE,
		KIND_READ,
		KIND_IDLE,
		KIND_ERROR
	} item_kind_t;

	localparam logic [7:0]  CMD_BASE         = 8'h60;
	localparam logic [15:0] START_HOLD_RESET = 16'd8;
	localparam logic [15:0] HALF_BIT_RESET   = 16'd40;
	localparam int          PHASE_W          = 5;
	localparam logic [PHASE_W-1:0] BEGIN_LAST_PHASE = PHASE_W'(17);
	localparam logic [PHASE_W-1:0] BYTE_LAST_PHASE  = PHASE_W'(15);

	typedef struct packed {
		cmd_t        cmd;
		logic [3:0]  reg_index;
		logic        is_read;
		logic [7:0]  write_byte;
		logic [7:0]  line_bits;
	} in_item_t;

	typedef struct packed {
		logic        chip_select;
		logic        serial_clock;
		logic        data_drive;
		logic        data_out;
		logic [15:0] hold_ticks;
		logic [7:0]  read_byte;
		logic        error_flag;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [15:0] value;
	} cfg_wr_t;

endpackage

### rtl/core/rtc3w_chan_if.sv
// ----------------------------------------------------------------------------
// rtc3w_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface rtc3w_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/three_wire_rtc_serial_master.sv
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master
// Turns begin, write, read and end items for a three-wire RTC link into a
// stream of pin-phase results, one result per clock cycle unless the output
// stalls. A begin item gives 18 results, a write or read item 16, an end
// item or a rejected data item 1; each phase passes through the single result
// register. The next item is taken in the cycle that its predecessor's final
// result is loaded, so items run back to back with no gap, and a result
// stalled on the output stalls the phase sequencer. Configuration writes are
// always ready and take effect at once.
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master (
	input  logic                            clk,
	input  logic                            arst_n,
	rtc3w_chan_if.sink                      items,
	rtc3w_chan_if.source                    results,
	rtc3w_chan_if.sink                      cfg
);
	import rtc3w_pkg::*;

	// configuration
	logic [15:0] start_hold_q;
	logic [15:0] half_bit_q;

	// transaction state, tracked at acceptance
	logic        open_q;

	// working stage
	logic               valid_s1;
	item_kind_t         kind_s1;
	logic [7:0]         shift_s1;
	logic [7:0]         lines_s1;
	logic [PHASE_W-1:0] phase_s1;

	// result register
	logic      out_valid_q;
	out_item_t out_q;

	in_item_t           in_item;
	cfg_wr_t            cfg_item;
	item_kind_t         in_kind;
	logic               advance;
	logic               gen;
	logic               phase_last;
	logic               accept;
	logic [PHASE_W-1:0] bit_phase;
	logic [2:0]         bit_idx;
	out_item_t          res;

	assign in_item  = items.data;
	assign cfg_item = cfg.data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_hold_q <= START_HOLD_RESET;
			half_bit_q   <= HALF_BIT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_item.index)
				CFG_START_HOLD: start_hold_q <= cfg_item.value;
				CFG_HALF_BIT:   half_bit_q   <= cfg_item.value;
				default:        ;
			endcase
		end
	end

	// Decide the kind on entry, against the state left by earlier items
	always_comb begin
		unique case (in_item.cmd)
			CMD_BEGIN: in_kind = KIND_BEGIN;
			CMD_END:   in_kind = KIND_IDLE;
			CMD_WRITE: in_kind = open_q ? KIND_WRITE : KIND_ERROR;
			CMD_READ:  in_kind = open_q ? KIND_READ : KIND_ERROR;
			default:   in_kind = KIND_IDLE;
		endcase
	end

	assign advance = !out_valid_q || results.ready;
	assign gen     = valid_s1 && advance;

	always_comb begin
		unique case (kind_s1)
			KIND_BEGIN:            phase_last = (phase_s1 == BEGIN_LAST_PHASE);
			KIND_WRITE, KIND_READ: phase_last = (phase_s1 == BYTE_LAST_PHASE);
			default:               phase_last = 1'b1;
		endcase
	end

	assign items.ready = !valid_s1 || (advance && phase_last);
	assign accept      = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			valid_s1 <= 1'b0;
			kind_s1  <= KIND_IDLE;
			phase_s1 <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			kind_s1  <= in_kind;
			phase_s1 <= '0;
			if (in_item.cmd == CMD_BEGIN) begin
				open_q <= 1'b1;
			end else if (in_item.cmd == CMD_END) begin
				open_q <= 1'b0;
			end
		end else if (gen) begin
			if (phase_last) begin
				valid_s1 <= 1'b0;
			end
			phase_s1 <= phase_s1 + PHASE_W'(1);
		end
	end

	// Payload of the working stage: command byte for begin, data byte otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			if (in_item.cmd == CMD_BEGIN) begin
				shift_s1 <= CMD_BASE | {3'b000, in_item.reg_index, in_item.is_read};
			end else begin
				shift_s1 <= in_item.write_byte;
			end
			lines_s1 <= in_item.line_bits;
		end
	end

	// Begin shifts MSB first after its two select phases
	assign bit_phase = phase_s1 - PHASE_W'(2);
	assign bit_idx   = ~bit_phase[3:1];

	always_comb begin
		res              = '0;
		res.serial_clock = 1'b1;
		res.last         = phase_last;
		unique case (kind_s1)
			KIND_BEGIN: begin
				res.chip_select = (phase_s1 != '0);
				if (phase_s1 < PHASE_W'(2)) begin
					res.hold_ticks = start_hold_q;
				end else begin
					res.serial_clock = phase_s1[0];
					res.data_drive   = 1'b1;
					res.data_out     = shift_s1[bit_idx];
					res.hold_ticks   = half_bit_q;
				end
			end
			KIND_WRITE: begin
				res.chip_select  = 1'b1;
				res.serial_clock = phase_s1[0];
				res.data_drive   = 1'b1;
				res.data_out     = shift_s1[phase_s1[3:1]];
				res.hold_ticks   = half_bit_q;
			end
			KIND_READ: begin
				res.chip_select  = 1'b1;
				res.serial_clock = phase_s1[0];
				res.hold_ticks   = half_bit_q;
				res.read_byte    = phase_last ? lines_s1 : 8'h00;
			end
			KIND_ERROR: begin
				res.error_flag = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (gen) begin
			out_q <= res;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> phase_s1 <= BEGIN_LAST_PHASE)
		else $error("phase counter overran the begin sequence");

	a_single_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (kind_s1 == KIND_IDLE || kind_s1 == KIND_ERROR) |-> phase_s1 == '0)
		else $error("single-result item went past its first phase");

	a_reject_closed: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !open_q && (in_item.cmd == CMD_WRITE || in_item.cmd == CMD_READ)
		|=> valid_s1 && kind_s1 == KIND_ERROR)
		else $error("data item outside a transaction was not flagged");

	a_error_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.error_flag |->
		!out_q.chip_select && out_q.last && out_q.hold_ticks == '0)
		else $error("error result is not an idle final phase");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> $stable(phase_s1) && valid_s1)
		else $error("phase advanced while the result was stalled");

endmodule

### dv/rtc3w_sb_pkg.sv
// ----------------------------------------------------------------------------
// rtc3w_sb_pkg
// Pin-phase predictor and result checker for the three-wire RTC serial master.
// Every accepted item is expanded into the phases that it should produce, and
// each result from the block is matched against the oldest phase still owed.
// ----------------------------------------------------------------------------
package rtc3w_sb_pkg;

	import rtc3w_pkg::*;

	class phase_scoreboard;
		logic [15:0] start_hold;
		logic [15:0] half_bit;
		bit          txn_open;
		out_item_t   owed_phases[$];
		int unsigned error_count;

		function new();
			start_hold  = START_HOLD_RESET;
			half_bit    = HALF_BIT_RESET;
			txn_open    = 1'b0;
			error_count = 0;
		endfunction

		function void note_cfg(cfg_wr_t w);
			case (w.index)
				CFG_START_HOLD: start_hold = w.value;
				CFG_HALF_BIT:   half_bit = w.value;
				default:        ;
			endcase
		endfunction

		function void push_phase(bit cs, bit sck, bit drv, bit dout, logic [15:0] hold,
				logic [7:0] rbyte, bit err);
			out_item_t p;
			p.chip_select  = cs;
			p.serial_clock = sck;
			p.data_drive   = drv;
			p.data_out     = dout;
			p.hold_ticks   = hold;
			p.read_byte    = rbyte;
			p.error_flag   = err;
			p.last         = 1'b0;
			owed_phases.push_back(p);
		endfunction

		// Expand one accepted item into the phases it owes
		function void note_item(in_item_t it);
			logic [7:0] cmd_byte;
			int         i;
			case (it.cmd)
				CMD_BEGIN: begin
					cmd_byte = CMD_BASE | {3'b000, it.reg_index, it.is_read};
					push_phase(1'b0, 1'b1, 1'b0, 1'b0, start_hold, 8'h00, 1'b0);
					push_phase(1'b1, 1'b1, 1'b0, 1'b0, start_hold, 8'h00, 1'b0);
					for (i = 7; i >= 0; i--) begin
						push_phase(1'b1, 1'b0, 1'b1, cmd_byte[i], half_bit, 8'h00, 1'b0);
						push_phase(1'b1, 1'b1, 1'b1, cmd_byte[i], half_bit, 8'h00, 1'b0);
					end
					txn_open = 1'b1;
				end
				CMD_END: begin
					push_phase(1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 8'h00, 1'b0);
					txn_open = 1'b0;
				end
				default: begin
					if (!txn_open) begin
						push_phase(1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 8'h00, 1'b1);
					end else if (it.cmd == CMD_WRITE) begin
						for (i = 0; i < 8; i++) begin
							push_phase(1'b1, 1'b0, 1'b1, it.write_byte[i], half_bit, 8'h00, 1'b0);
							push_phase(1'b1, 1'b1, 1'b1, it.write_byte[i], half_bit, 8'h00, 1'b0);
						end
					end else begin
						// sampled byte appears only on the final rising phase
						for (i = 0; i < 8; i++) begin
							push_phase(1'b1, 1'b0, 1'b0, 1'b0, half_bit, 8'h00, 1'b0);
							push_phase(1'b1, 1'b1, 1'b0, 1'b0, half_bit,
								(i == 7) ? it.line_bits : 8'h00, 1'b0);
						end
					end
				end
			endcase
			owed_phases[owed_phases.size() - 1].last = 1'b1;
		endfunction

		function string show(out_item_t p);
			return $sformatf("cs %b sck %b drv %b dout %b hold %0d rbyte %h err %b last %b",
				p.chip_select, p.serial_clock, p.data_drive, p.data_out, p.hold_ticks,
				p.read_byte, p.error_flag, p.last);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (owed_phases.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("ERROR: result with nothing owed: %s", show(got));
				return;
			end
			want = owed_phases.pop_front();
			if (got.chip_select !== want.chip_select || got.serial_clock !== want.serial_clock ||
					got.data_drive !== want.data_drive || got.data_out !== want.data_out ||
					got.hold_ticks !== want.hold_ticks || got.read_byte !== want.read_byte ||
					got.error_flag !== want.error_flag || got.last !== want.last) begin
				error_count++;
				if (error_count <= 10) begin
					$display("ERROR: phase mismatch at %0t", $realtime);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

endpackage

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives begin, write, read and end items into the three-wire RTC serial
// master under several timing settings and checks every pin-phase result.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rtc3w_pkg::*;
	import rtc3w_sb_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int IDLE_PCT        = 36;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int HOLD_OFF_AT     = 500;
	localparam int PHASE_ITEMS     = 70;
	// indexes past the last register, writes to them are dropped
	localparam logic [1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [1:0] CFG_SPARE_3 = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rtc3w_chan_if #(.payload_t(in_item_t))  items_if ();
	rtc3w_chan_if #(.payload_t(out_item_t)) results_if ();
	rtc3w_chan_if #(.payload_t(cfg_wr_t))   cfg_if ();

	three_wire_rtc_serial_master dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	phase_scoreboard sb = new();
	int unsigned     items_sent = 0;
	int unsigned     results_seen = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (items_if.valid && items_if.ready)
			sb.note_item(items_if.data);
		if (cfg_if.valid && cfg_if.ready)
			sb.note_cfg(cfg_if.data);
		if (results_if.valid && results_if.ready) begin
			sb.check_result(results_if.data);
			results_seen++;
		end
	end

	// Result side: random stalls, one long hold-off, and a stall-free stretch
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	always @(negedge clk) begin
		if (!hold_done && results_seen >= HOLD_OFF_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_OFF_CYCLES;
			results_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			results_if.ready <= 1'b0;
		end else if (results_seen >= 1400 && results_seen < 2200) begin
			results_if.ready <= 1'b1;
		end else begin
			results_if.ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic in_item_t make_item(cmd_t c, logic [3:0] r, logic rd,
			logic [7:0] wb, logic [7:0] lines);
		in_item_t it;
		it.cmd        = c;
		it.reg_index  = r;
		it.is_read    = rd;
		it.write_byte = wb;
		it.line_bits  = lines;
		return it;
	endfunction

	function automatic in_item_t rand_item(cmd_t c);
		return make_item(c, 4'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
	endfunction

	// Entered and left at a falling edge; valid stays high for the next item
	task automatic send_item(input in_item_t it);
		if (items_sent < 150 || items_sent >= 200) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				items_if.valid <= 1'b0;
				@(negedge clk);
			end
		end
		items_if.valid <= 1'b1;
		items_if.data  <= it;
		do @(posedge clk); while (!items_if.ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_wr_t w;
		w.index = idx;
		w.value = value;
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= w;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
	endtask

	// Drop valid, wait for every owed phase, then let the pipeline empty
	task automatic settle();
		items_if.valid <= 1'b0;
		do @(negedge clk); while (sb.owed_phases.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic run_random(input int count);
		int n;
		n = 0;
		while (n < count) begin
			if ($urandom_range(99) < 15) begin
				// noise: any command, in or out of a transaction
				send_item(rand_item(cmd_t'($urandom_range(3))));
				n++;
			end else begin
				send_item(rand_item(CMD_BEGIN));
				n++;
				repeat ($urandom_range(1, 3)) begin
					send_item(rand_item($urandom_range(1) ? CMD_READ : CMD_WRITE));
					n++;
				end
				send_item(rand_item(CMD_END));
				n++;
			end
		end
	endtask

	initial begin
		items_if.valid   = 1'b0;
		items_if.data    = '0;
		cfg_if.valid     = 1'b0;
		cfg_if.data      = '0;
		results_if.ready = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: closed-link cases, both extremes, restart while open
		send_item(make_item(CMD_END,   4'h0, 1'b0, 8'h00, 8'h00));
		send_item(make_item(CMD_WRITE, 4'h3, 1'b1, 8'hff, 8'hff));
		send_item(make_item(CMD_READ,  4'hc, 1'b0, 8'h00, 8'hff));
		send_item(make_item(CMD_BEGIN, 4'h0, 1'b0, 8'h00, 8'h00));
		send_item(make_item(CMD_WRITE, 4'h0, 1'b0, 8'h00, 8'h00));
		send_item(make_item(CMD_WRITE, 4'hf, 1'b1, 8'hff, 8'hff));
		send_item(make_item(CMD_READ,  4'h0, 1'b0, 8'hff, 8'h00));
		send_item(make_item(CMD_READ,  4'hf, 1'b1, 8'h00, 8'hff));
		send_item(make_item(CMD_END,   4'hf, 1'b1, 8'hff, 8'hff));
		send_item(make_item(CMD_BEGIN, 4'hf, 1'b1, 8'hff, 8'hff));
		send_item(make_item(CMD_READ,  4'h5, 1'b0, 8'h3c, 8'ha5));
		send_item(make_item(CMD_WRITE, 4'ha, 1'b1, 8'h5a, 8'hc3));
		send_item(make_item(CMD_BEGIN, 4'h9, 1'b0, 8'h00, 8'h00));
		send_item(make_item(CMD_WRITE, 4'h6, 1'b0, 8'h01, 8'h80));
		send_item(make_item(CMD_READ,  4'h6, 1'b1, 8'h80, 8'h01));
		send_item(make_item(CMD_END,   4'h0, 1'b0, 8'h00, 8'h00));
		send_item(make_item(CMD_END,   4'h0, 1'b0, 8'h00, 8'h00));
		settle();

		write_reg(CFG_START_HOLD, 16'd0);
		write_reg(CFG_HALF_BIT, 16'd1);
		write_reg(CFG_SPARE_2, 16'($urandom));
		cfg_if.valid <= 1'b0;
		run_random(PHASE_ITEMS);
		settle();

		write_reg(CFG_START_HOLD, 16'hffff);
		write_reg(CFG_HALF_BIT, 16'hffff);
		write_reg(CFG_SPARE_3, 16'($urandom));
		cfg_if.valid <= 1'b0;
		run_random(PHASE_ITEMS);
		settle();

		// zero half-bit time passes straight through
		write_reg(CFG_START_HOLD, 16'($urandom));
		write_reg(CFG_HALF_BIT, 16'd0);
		cfg_if.valid <= 1'b0;
		run_random(PHASE_ITEMS);
		settle();

		write_reg(CFG_START_HOLD, 16'($urandom));
		write_reg(CFG_HALF_BIT, 16'($urandom));
		cfg_if.valid <= 1'b0;
		run_random(PHASE_ITEMS);
		settle();

		if (sb.error_count == 0 && sb.owed_phases.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
